// ----- rtl/core/fpsq_pkg.sv -----
// ----------------------------------------------------------------------------
// fpsq_pkg: shared types and constants for the four pot smoothing quantizer
// Channel codes, fixed widths and the per-channel result bundle.
// ----------------------------------------------------------------------------
package fpsq_pkg;

    localparam int RUN_MAX_BITS = 17;
    localparam int NOM_BITS     = 13;
    localparam int SET_BITS     = 7;

    localparam logic [1:0] CH_MASTER_VOL = 2'd0;
    localparam logic [1:0] CH_TONE_VOL   = 2'd1;
    localparam logic [1:0] CH_TONE_FREQ  = 2'd2;
    localparam logic [1:0] CH_SPEED      = 2'd3;

    typedef logic [RUN_MAX_BITS-1:0] run_wide_t;
    typedef logic [NOM_BITS-1:0]     nom_t;
    typedef logic [SET_BITS-1:0]     setting_t;

    typedef struct packed {
        logic     changed;
        setting_t setting;
        nom_t     nominal;
    } result_t;

endpackage

// ----- rtl/core/four_pot_smoothing_quantizer_unit.sv -----
// ----------------------------------------------------------------------------
// four_pot_smoothing_quantizer_unit: four channel pot smoothing quantizer
// A sample is registered into the compute stage on acceptance and its result
// into the output registers when that stage moves; stalls hold it. Throughput:
// one sample per cycle when not stalled, set by the per-channel state read at
// acceptance and written back one stage later in two 4-entry memories.
// Reset: turn, pipeline valids and per-entry valid bits clear; memory entries
// not yet written read as zero.
// ----------------------------------------------------------------------------
module four_pot_smoothing_quantizer_unit #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             channel,
    output logic                   changed,
    output logic [6:0]             setting
);

    localparam int RUN_BITS = SAMPLE_BITS + 1;

    logic [RUN_BITS-1:0]          run_mem [0:3];
    fpsq_pkg::nom_t               nom_mem [0:3];

    logic [1:0]                   turn_reg;
    logic [3:0]                   ent_valid_reg;

    logic                         s1_valid_reg;
    logic [1:0]                   s1_ch_reg;
    logic [SAMPLE_BITS-1:0]       s1_sample_reg;
    logic [RUN_BITS-1:0]          rd_run_reg;
    fpsq_pkg::nom_t               rd_nom_reg;
    logic                         rd_ok_reg;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [1:0]                   channel_reg;
    logic                         changed_reg;
    fpsq_pkg::setting_t           setting_reg;

    logic                         in_take;
    logic                         s1_go;
    logic [RUN_BITS-1:0]          run_cur;
    fpsq_pkg::nom_t               nom_cur;
    logic [RUN_BITS-1:0]          run_new;
    fpsq_pkg::result_t            quant;

    assign s1_go    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;

    // Channels come round in turn, so an entry is touched again only four
    // transactions later; no forwarding path is needed.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rd_run_reg    <= run_mem[turn_reg];
            rd_nom_reg    <= nom_mem[turn_reg];
            s1_sample_reg <= sample;
            s1_ch_reg     <= turn_reg;
        end
        if (s1_go)
        begin
            run_mem[s1_ch_reg] <= run_new;
            nom_mem[s1_ch_reg] <= quant.nominal;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_reg      <= '0;
            ent_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                turn_reg  <= turn_reg + 2'd1;
                rd_ok_reg <= ent_valid_reg[turn_reg];
            end
            if (s1_go)
            begin
                ent_valid_reg[s1_ch_reg] <= 1'b1;
            end
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Unwritten entries read as zero.
    assign run_cur = rd_ok_reg ? rd_run_reg : '0;
    assign nom_cur = rd_ok_reg ? rd_nom_reg : '0;
    assign run_new = (run_cur >> 1) + {1'b0, s1_sample_reg};

    fpsq_quant u_quant (
        .channel   (s1_ch_reg),
        .run_value (fpsq_pkg::run_wide_t'(run_new)),
        .nom_value (nom_cur),
        .result    (quant)
    );

    // Hold the result while stalled; load the next one as soon as it moves.
    assign out_valid_next = s1_go || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            channel_reg <= s1_ch_reg;
            changed_reg <= quant.changed;
            setting_reg <= quant.setting;
        end
    end

    assign out_valid = out_valid_reg;
    assign channel   = channel_reg;
    assign changed   = changed_reg;
    assign setting   = setting_reg;

`ifndef SYNTH
    a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted transaction did not reach the compute stage");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    a_turn_follows_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (turn_reg == s1_ch_reg + 2'd1))
        else $error("turn out of step with the compute stage");

    a_idle_setting_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !changed) |-> (setting == 7'd0))
        else $error("setting nonzero without a change");

    a_freq_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && changed && channel == fpsq_pkg::CH_TONE_FREQ)
            |-> (setting >= 7'd40 && setting <= 7'd103))
        else $error("side-tone frequency setting out of range");
`endif

endmodule

// ----- rtl/core/fpsq_quant.sv -----
// ----------------------------------------------------------------------------
// fpsq_quant: threshold test and quantizer
// Compares the running value with the nominal value of one channel and, past
// the channel threshold, derives the inverted setting and the new nominal.
// ----------------------------------------------------------------------------
module fpsq_quant (
    input  logic [1:0]          channel,
    input  fpsq_pkg::run_wide_t run_value,
    input  fpsq_pkg::nom_t      nom_value,
    output fpsq_pkg::result_t   result
);

    fpsq_pkg::run_wide_t nom_wide;
    fpsq_pkg::run_wide_t diff;
    fpsq_pkg::run_wide_t threshold;
    fpsq_pkg::setting_t  level;
    fpsq_pkg::setting_t  top;
    fpsq_pkg::nom_t      nom_new;

    assign nom_wide = fpsq_pkg::run_wide_t'(nom_value);
    assign diff     = (run_value >= nom_wide) ? (run_value - nom_wide)
                                              : (nom_wide - run_value);

    // Fixed shift and mask per channel; nominal moves to the interval midpoint.
    always_comb
    begin
        case (channel)
            fpsq_pkg::CH_MASTER_VOL, fpsq_pkg::CH_TONE_VOL:
            begin
                threshold = fpsq_pkg::run_wide_t'(64);
                level     = run_value[12:6];
                top       = 7'd127;
                nom_new   = {run_value[12:6], 6'b100000};
            end
            fpsq_pkg::CH_TONE_FREQ:
            begin
                threshold = fpsq_pkg::run_wide_t'(128);
                level     = {1'b0, run_value[12:7]};
                top       = 7'd103;
                nom_new   = {run_value[12:7], 7'b1000000};
            end
            fpsq_pkg::CH_SPEED:
            begin
                threshold = fpsq_pkg::run_wide_t'(256);
                level     = {2'b00, run_value[12:8]};
                top       = 7'd31;
                nom_new   = {run_value[12:8], 8'b10000000};
            end
            default:
            begin
                threshold = fpsq_pkg::run_wide_t'(64);
                level     = run_value[12:6];
                top       = 7'd127;
                nom_new   = {run_value[12:6], 6'b100000};
            end
        endcase
    end

    always_comb
    begin
        result.changed = (diff > threshold);
        result.setting = result.changed ? (top - level) : '0;
        result.nominal = result.changed ? nom_new : nom_value;
    end

endmodule

// ----- test/tb_four_pot_smoothing_quantizer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_four_pot_smoothing_quantizer_unit: self-checking bench for the quantizer
// Runs a directed table of pot readings, then about a thousand drifting and
// noisy samples. Both sides idle and stall at random. Every reading is compared
// with its table entry or a behavioral model of the smoothing and quantizing.
// ----------------------------------------------------------------------------
module tb_four_pot_smoothing_quantizer_unit;

    localparam int SMP_BITS     = 12;
    localparam int RANDOM_ITEMS = 1025;
    localparam int SETTLE_TAIL  = 8;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [1:0]         ch;
        logic               chg;
        fpsq_pkg::setting_t set;
    } reading_t;

    typedef struct packed {
        logic [SMP_BITS-1:0] smp;
        logic                typed;
        reading_t            want;
    } row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [SMP_BITS-1:0] sample = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          channel;
    logic                changed;
    logic [6:0]          setting;

    // per-channel quantizer constants
    int unsigned limit_tbl [4] = '{64, 64, 128, 256};
    int unsigned shift_tbl [4] = '{6, 6, 7, 8};
    int unsigned mask_tbl  [4] = '{127, 127, 63, 31};
    int unsigned top_tbl   [4] = '{127, 127, 103, 31};
    int unsigned mid_tbl   [4] = '{32, 32, 64, 128};

    logic [1:0]     turn_model;
    logic [12:0]    smooth_model [4];
    fpsq_pkg::nom_t center_model [4];

    reading_t    expected_readings [$];
    row_t        rows [$];
    int          mismatch_count = 0;
    int          burst_left = 0;
    int          pot_level [4];
    int          stall_left = 0;
    int          stall_mode = 0;

    four_pot_smoothing_quantizer_unit #(.SAMPLE_BITS(SMP_BITS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .channel   (channel),
        .changed   (changed),
        .setting   (setting)
    );

    always #2 clk = ~clk;

    // smooth the sample into its channel and quantize on a large swing
    task automatic predict_reading(input logic [SMP_BITS-1:0] smp, output reading_t r);
        logic [1:0]  ch;
        int unsigned run;
        int unsigned nom;
        int unsigned diff;
        int unsigned v;
        ch   = turn_model;
        run  = ((smooth_model[ch] >> 1) + smp) & 32'h1FFF;
        nom  = center_model[ch];
        diff = (run >= nom) ? run - nom : nom - run;
        r.ch  = ch;
        r.chg = 1'b0;
        r.set = '0;
        if (diff > limit_tbl[ch])
        begin
            v     = (run >> shift_tbl[ch]) & mask_tbl[ch];
            r.chg = 1'b1;
            r.set = fpsq_pkg::setting_t'(top_tbl[ch] - v);
            center_model[ch] =
                fpsq_pkg::nom_t'(((v << shift_tbl[ch]) + mid_tbl[ch]) & 32'h1FFF);
        end
        smooth_model[ch] = run[12:0];
        turn_model = ch + 2'd1;
    endtask

    task automatic add_row(input logic [SMP_BITS-1:0] smp, input logic typed,
                           input logic [1:0] ch, input logic chg,
                           input fpsq_pkg::setting_t set);
        row_t row;
        row.smp      = smp;
        row.typed    = typed;
        row.want.ch  = ch;
        row.want.chg = chg;
        row.want.set = set;
        rows.push_back(row);
    endtask

    // present one sample, hold it until accepted, then log the expected reading
    task automatic push_sample(input logic [SMP_BITS-1:0] s, input logic typed,
                               input reading_t want);
        reading_t guess;
        sample   <= s;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_reading(s, guess);
        expected_readings.push_back(typed ? want : guess);
    endtask

    // end a burst now and then with a short gap
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(6, 1);
            if ($urandom_range(7, 0) == 0)
                burst_left = $urandom_range(150, 60);
            else
                burst_left = $urandom_range(24, 1);
            in_valid <= 1'b0;
            sample   <= SMP_BITS'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off the sender until every reading is back
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_readings.size() != 0);
    endtask

    function automatic int clip12(input int x);
        if (x < 0)
            return 0;
        if (x > 4095)
            return 4095;
        return x;
    endfunction

    // receiver stall pattern: free, light, heavy or solid stretches
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left == 0)
        begin
            stall_left <= $urandom_range(40, 1);
            stall_mode <= $urandom_range(3, 0);
            out_stall  <= 1'b0;
        end
        else
        begin
            stall_left <= stall_left - 1;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(99, 0) < 30);
                2:       out_stall <= ($urandom_range(99, 0) < 80);
                default: out_stall <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin : reading_check
        reading_t got;
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {channel, changed, setting};
            if (expected_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected reading: channel=%0d changed=%0b setting=%0d",
                             got.ch, got.chg, got.set);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (got.ch !== want.ch || got.chg !== want.chg || got.set !== want.set)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"reading mismatch: channel %0d/%0d changed %0b/%0b",
                                  " setting %0d/%0d (expected/actual)"},
                                 want.ch, got.ch, want.chg, got.chg, want.set, got.set);
                end
            end
        end
    end

    initial
    begin : stimulus
        row_t        row;
        int          k;
        int          ch;
        int          pick;
        logic [SMP_BITS-1:0] s;

        turn_model = '0;
        for (k = 0; k < 4; k++)
        begin
            smooth_model[k] = '0;
            center_model[k] = '0;
            pot_level[k]    = $urandom_range(4095, 0);
        end

        // quiet after reset, full scale on the other channels
        add_row(12'd0,    1'b1, fpsq_pkg::CH_MASTER_VOL, 1'b0, 7'd0);
        add_row(12'd4095, 1'b1, fpsq_pkg::CH_TONE_VOL,   1'b1, 7'd64);
        add_row(12'd4095, 1'b1, fpsq_pkg::CH_TONE_FREQ,  1'b1, 7'd72);
        add_row(12'd4095, 1'b1, fpsq_pkg::CH_SPEED,      1'b1, 7'd16);
        // swing equal to the threshold is no change
        add_row(12'd64,   1'b1, fpsq_pkg::CH_MASTER_VOL, 1'b0, 7'd0);
        // drive all channels toward the running-value ceiling
        for (k = 0; k < 12; k++)
            add_row(12'd4095, 1'b0, fpsq_pkg::CH_MASTER_VOL, 1'b0, 7'd0);
        for (k = 0; k < 4; k++)
            add_row(12'd0, 1'b0, fpsq_pkg::CH_MASTER_VOL, 1'b0, 7'd0);
        add_row(12'hAAA, 1'b0, fpsq_pkg::CH_MASTER_VOL, 1'b0, 7'd0);
        add_row(12'h555, 1'b0, fpsq_pkg::CH_MASTER_VOL, 1'b0, 7'd0);
        add_row(12'hAAA, 1'b0, fpsq_pkg::CH_MASTER_VOL, 1'b0, 7'd0);
        add_row(12'h555, 1'b0, fpsq_pkg::CH_MASTER_VOL, 1'b0, 7'd0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < rows.size(); k++)
        begin
            row = rows[k];
            push_sample(row.smp, row.typed, row.want);
            pace();
        end
        settle();

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS / 2)
                settle();
            ch   = turn_model;
            pick = $urandom_range(99, 0);
            if (pick < 10)
                s = SMP_BITS'($urandom);
            else if (pick < 16)
                s = $urandom_range(1, 0) ? 12'hFFF : 12'h000;
            else
            begin
                // pot turned now and then, otherwise slow drift with jitter
                if ($urandom_range(19, 0) == 0)
                    pot_level[ch] = $urandom_range(4095, 0);
                else
                    pot_level[ch] = clip12(pot_level[ch] + int'($urandom_range(40, 0)) - 20);
                s = SMP_BITS'(clip12(pot_level[ch] + int'($urandom_range(8, 0)) - 4));
            end
            push_sample(s, 1'b0, '0);
            pace();
        end

        settle();
        repeat (SETTLE_TAIL) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_four_pot_smoothing_quantizer_unit: done, clean");
        else
            $display("tb_four_pot_smoothing_quantizer_unit: done, errors");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("tb_four_pot_smoothing_quantizer_unit: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/fpsq_pkg.sv
rtl/core/fpsq_quant.sv
rtl/core/four_pot_smoothing_quantizer_unit.sv
test/tb_four_pot_smoothing_quantizer_unit.sv
